// ----- rtl/interval_timer_channel_macros.svh -----
// Assertion macros for the interval timer channel.
// Used by interval_timer_channel.sv; expects clk and arst_n in scope.
`ifndef INTERVAL_TIMER_CHANNEL_MACROS_SVH
`define INTERVAL_TIMER_CHANNEL_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ITC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("interval timer channel: assertion failed");

// Next-cycle implication, checked outside reset.
`define ITC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("interval timer channel: assertion failed");

`endif

// ----- rtl/itc_pkg.sv -----
// Shared types and codes for the interval timer channel.
// No dependencies; imported by itc_core and interval_timer_channel.
`default_nettype none

package itc_pkg;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	localparam logic [1:0] PORT_DATA = 2'd0;
	localparam logic [1:0] PORT_CMD  = 2'd3;

	localparam logic [1:0] SEL_CH0      = 2'd0;
	localparam logic [1:0] ACCESS_LATCH = 2'd0;
	localparam logic [2:0] MODE_ONESHOT = 3'd0;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] port;
		logic [7:0] write_data;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       out_level;
		logic       irq_pulse;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/itc_core.sv -----
// Channel 0 counter state and per-beat update logic.
// Depends on itc_pkg; state advances only when en is high.
`default_nettype none

module itc_core import itc_pkg::*; (
	input  wire     clk,
	input  wire     arst_n,
	input  wire     en,
	input  item_t   item,
	output result_t res
);

	logic        periodic_q, periodic_d;
	logic [15:0] reload_q, reload_d;
	logic [15:0] count_q, count_d;
	logic        wr_hi_q, wr_hi_d;
	logic        rd_hi_q, rd_hi_d;
	logic [15:0] latch_q, latch_d;
	logic        latch_vld_q, latch_vld_d;
	logic        load_pend_q, load_pend_d;
	logic        counting_q, counting_d;
	logic        out_q, out_d;
	logic [7:0]  rd_byte;
	logic [15:0] count_dec;
	logic [15:0] rd_word;

	assign count_dec = count_q - 16'd1;
	assign rd_word   = latch_vld_q ? latch_q : count_q;

	always_comb begin
		periodic_d  = periodic_q;
		reload_d    = reload_q;
		count_d     = count_q;
		wr_hi_d     = wr_hi_q;
		rd_hi_d     = rd_hi_q;
		latch_d     = latch_q;
		latch_vld_d = latch_vld_q;
		load_pend_d = load_pend_q;
		counting_d  = counting_q;
		out_d       = out_q;
		rd_byte     = 8'd0;
		unique case (item.kind)
			KIND_WRITE: begin
				if (item.port == PORT_CMD && item.write_data[7:6] == SEL_CH0) begin
					if (item.write_data[5:4] == ACCESS_LATCH) begin
						if (!latch_vld_q) begin
							latch_d     = count_q;
							latch_vld_d = 1'b1;
						end
					end else begin
						// any mode other than 0 runs as rate generator
						periodic_d  = (item.write_data[3:1] != MODE_ONESHOT);
						counting_d  = 1'b0;
						load_pend_d = 1'b0;
						latch_vld_d = 1'b0;
						wr_hi_d     = 1'b0;
						rd_hi_d     = 1'b0;
						out_d       = (item.write_data[3:1] != MODE_ONESHOT);
					end
				end else if (item.port == PORT_DATA) begin
					if (!wr_hi_q) begin
						reload_d = {reload_q[15:8], item.write_data};
						wr_hi_d  = 1'b1;
						if (!periodic_q) begin
							counting_d = 1'b0;
							out_d      = 1'b0;
						end
					end else begin
						reload_d    = {item.write_data, reload_q[7:0]};
						wr_hi_d     = 1'b0;
						load_pend_d = 1'b1;
					end
				end
			end
			KIND_READ: begin
				if (item.port == PORT_DATA) begin
					if (!rd_hi_q) begin
						rd_byte = rd_word[7:0];
						rd_hi_d = 1'b1;
					end else begin
						rd_byte     = rd_word[15:8];
						rd_hi_d     = 1'b0;
						latch_vld_d = 1'b0;
					end
				end
			end
			KIND_TICK: begin
				priority if (load_pend_q && (!counting_q || !periodic_q)) begin
					count_d     = reload_q;
					load_pend_d = 1'b0;
					counting_d  = 1'b1;
					if (periodic_q)
						out_d = 1'b1;
				end else if (!counting_q) begin
					count_d = count_q;
				end else if (!periodic_q) begin
					count_d = count_dec;
					if (count_dec == 16'd0)
						out_d = 1'b1;
				end else if (count_q == 16'd1) begin
					// terminal count in rate mode: reload and end the low pulse
					count_d     = reload_q;
					load_pend_d = 1'b0;
					out_d       = 1'b1;
				end else begin
					count_d = count_dec;
					if (count_dec == 16'd1)
						out_d = 1'b0;
				end
			end
			default: begin
				rd_byte = 8'd0;
			end
		endcase
	end

	assign res.read_data = rd_byte;
	assign res.out_level = out_d;
	assign res.irq_pulse = out_d & ~out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			periodic_q  <= 1'b0;
			reload_q    <= 16'd0;
			count_q     <= 16'd0;
			wr_hi_q     <= 1'b0;
			rd_hi_q     <= 1'b0;
			latch_q     <= 16'd0;
			latch_vld_q <= 1'b0;
			load_pend_q <= 1'b0;
			counting_q  <= 1'b0;
			out_q       <= 1'b0;
		end else if (en) begin
			periodic_q  <= periodic_d;
			reload_q    <= reload_d;
			count_q     <= count_d;
			wr_hi_q     <= wr_hi_d;
			rd_hi_q     <= rd_hi_d;
			latch_q     <= latch_d;
			latch_vld_q <= latch_vld_d;
			load_pend_q <= load_pend_d;
			counting_q  <= counting_d;
			out_q       <= out_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/interval_timer_channel.sv -----
// Interval timer channel 0: each input beat passes the input register, then the
// result register. Throughput one beat per cycle, set by the state update in
// itc_core between the two registers, while out_stall holds no valid result.
// Asynchronous active-low reset clears all counter state, sets the core output low,
// and empties both registers; the registered out_level port itself is not reset.
`default_nettype none

`include "interval_timer_channel_macros.svh"

module interval_timer_channel import itc_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [1:0] kind,
	input  wire  [1:0] port,
	input  wire  [7:0] write_data,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] read_data,
	output logic       out_level,
	output logic       irq_pulse
);

	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	logic    in_acc;
	result_t res;
	logic    out_valid_q;
	result_t res_q;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc || advance) begin
			valid_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= '{kind: kind, port: port, write_data: write_data};
		end
	end

	itc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = res_q.read_data;
	assign out_level = res_q.out_level;
	assign irq_pulse = res_q.irq_pulse;

	`ITC_ASSERT_IMPL(a_irq_high, out_valid_q && res_q.irq_pulse, res_q.out_level)
	`ITC_ASSERT_IMPL(a_stall_cause, in_stall, valid_s1 && out_valid_q && out_stall)
	`ITC_ASSERT_NEXT(a_beat_lands, advance, out_valid_q)

endmodule

`default_nettype wire
